/* src/cpp_pkg.sv */
// shared types, widths and constants for the cascaded pitch controller
package cpp_pkg;

    // fixed-point format of the signals
    localparam int FRAC_BITS_DEF = 12;

    // port widths
    localparam int GAIN_W    = 20;
    localparam int DATA_W    = 24;
    localparam int OUT_W     = 16;
    localparam int CFG_IDX_W = 3;

    // datapath widths
    localparam int MUL_A_W = 26;
    localparam int MUL_P_W = MUL_A_W + GAIN_W + 1;
    localparam int ACC_W   = 49;
    localparam int TGT_W   = 23;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KI = 3'd4;

    // gain values after reset
    localparam logic [GAIN_W-1:0] RST_OUTER_KP = 20'd10240;
    localparam logic [GAIN_W-1:0] RST_OUTER_KI = 20'd0;
    localparam logic [GAIN_W-1:0] RST_OUTER_KD = 20'd128000;
    localparam logic [GAIN_W-1:0] RST_INNER_KP = 20'd768000;
    localparam logic [GAIN_W-1:0] RST_INNER_KI = 20'd128000;

    // output voltage limit
    localparam longint VOLT_LIM = 64'sd26000;

    // gains of the outer and inner loops
    typedef struct packed {
        logic [GAIN_W-1:0] outer_kp;
        logic [GAIN_W-1:0] outer_ki;
        logic [GAIN_W-1:0] outer_kd;
        logic [GAIN_W-1:0] inner_kp;
        logic [GAIN_W-1:0] inner_ki;
    } t_gains;

endpackage

/* src/cpp_cfg.sv */
// gain register file written through the configuration channel
module cpp_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cpp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cpp_pkg::GAIN_W-1:0]        i_cfg_data,
    output cpp_pkg::t_gains                   o_gains
);

    cpp_pkg::t_gains r_gains;

    // writes are taken at any time
    assign o_cfg_ready = 1'b1;
    assign o_gains     = r_gains;

    // register write, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.outer_kp <= cpp_pkg::RST_OUTER_KP;
            r_gains.outer_ki <= cpp_pkg::RST_OUTER_KI;
            r_gains.outer_kd <= cpp_pkg::RST_OUTER_KD;
            r_gains.inner_kp <= cpp_pkg::RST_INNER_KP;
            r_gains.inner_ki <= cpp_pkg::RST_INNER_KI;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cpp_pkg::REG_OUTER_KP: r_gains.outer_kp <= i_cfg_data;
                cpp_pkg::REG_OUTER_KI: r_gains.outer_ki <= i_cfg_data;
                cpp_pkg::REG_OUTER_KD: r_gains.outer_kd <= i_cfg_data;
                cpp_pkg::REG_INNER_KP: r_gains.inner_kp <= i_cfg_data;
                cpp_pkg::REG_INNER_KI: r_gains.inner_ki <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* src/cpp_mul.sv */
// shared signed-by-unsigned multiplier with registered product
module cpp_mul (
    input  logic                                  i_clk,
    input  logic signed [cpp_pkg::MUL_A_W-1:0]    i_a,
    input  logic        [cpp_pkg::GAIN_W-1:0]     i_b,
    output logic signed [cpp_pkg::MUL_P_W-1:0]    o_p
);

    logic signed [cpp_pkg::GAIN_W:0]  b_ext;
    logic signed [cpp_pkg::MUL_P_W-1:0] r_p;

    // gain is unsigned, widen with a zero sign bit
    assign b_ext = $signed({1'b0, i_b});

    // product register
    always_ff @(posedge i_clk) begin
        r_p <= i_a * b_ext;
    end

    assign o_p = r_p;

endmodule

/* src/cascaded_pid_pi_pitch_controller.sv */
// top level: sequencer and datapath of the cascaded pitch controller
//
// Each transfer on the input channel carries an angle error and a measured pitch rate and
// yields one drive voltage. An outer PID turns the angle error into a speed target and an
// inner PI, with tripled positive speed error for gravity compensation, turns that into a
// voltage saturated at +-26000 and truncated toward zero. A single registered multiplier is
// walked through the five gain products by a small sequencer; o_ready is high only between
// items. The finished voltage sits in an output register, so a new item can be taken while
// it waits. Gains are to be written through the configuration channel only while the block
// is idle; the block itself does not enforce this.
module cascaded_pid_pi_pitch_controller #(
    parameter int FRAC_BITS = cpp_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [cpp_pkg::DATA_W-1:0]    i_angle_error,
    input  logic signed [cpp_pkg::DATA_W-1:0]    i_measured_speed,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [cpp_pkg::OUT_W-1:0]     o_drive_voltage,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cpp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [cpp_pkg::GAIN_W-1:0]           i_cfg_data
);

    localparam int AW        = cpp_pkg::ACC_W;
    localparam int DW        = cpp_pkg::DATA_W;
    localparam int MW        = cpp_pkg::MUL_A_W;
    localparam int TW        = cpp_pkg::TGT_W;
    localparam int OW        = cpp_pkg::OUT_W;
    localparam int INT_W     = FRAC_BITS;
    localparam int OUT_SHIFT = FRAC_BITS + 8;

    // fixed-point limits
    localparam logic signed [AW-1:0] ANG_LIM = AW'(64'sd1 <<< (FRAC_BITS - 2));
    localparam logic signed [AW-1:0] SPD_LIM =
        AW'(((64'sd314 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);
    localparam logic signed [AW-1:0] VMAX =
        AW'(((64'sd31415927 <<< FRAC_BITS) + 64'sd500000) / 64'sd1000000);
    localparam logic signed [AW-1:0] OUT_LIM = AW'(cpp_pkg::VOLT_LIM <<< OUT_SHIFT);
    localparam logic signed [AW-1:0] RND_ADD = AW'((64'sd1 <<< OUT_SHIFT) - 64'sd1);
    localparam logic signed [OW-1:0] V_LIM   = OW'(cpp_pkg::VOLT_LIM);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_AINT = 4'd1;
    localparam logic [3:0] S_M0   = 4'd2;
    localparam logic [3:0] S_M1   = 4'd3;
    localparam logic [3:0] S_M2   = 4'd4;
    localparam logic [3:0] S_M3   = 4'd5;
    localparam logic [3:0] S_TGT  = 4'd6;
    localparam logic [3:0] S_V    = 4'd7;
    localparam logic [3:0] S_TRI  = 4'd8;
    localparam logic [3:0] S_SINT = 4'd9;
    localparam logic [3:0] S_M4   = 4'd10;
    localparam logic [3:0] S_M5   = 4'd11;
    localparam logic [3:0] S_M6   = 4'd12;
    localparam logic [3:0] S_CLMP = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    function automatic logic signed [AW-1:0] sat(input logic signed [AW-1:0] x,
                                                 input logic signed [AW-1:0] lim);
        logic signed [AW-1:0] r;
        r = x;
        if (x > lim) r = lim;
        else if (x < -lim) r = -lim;
        return r;
    endfunction

    logic [3:0]               r_state, n_state;
    logic signed [DW-1:0]     r_e, r_meas, r_prev;
    logic signed [DW:0]       r_d;
    logic signed [INT_W-1:0]  r_ai, r_si;
    logic signed [TW-1:0]     r_tgt;
    logic signed [MW-1:0]     r_v;
    logic signed [AW-1:0]     r_acc;
    logic                     r_out_valid;
    logic signed [OW-1:0]     r_vout;

    cpp_pkg::t_gains          gains;
    logic signed [MW-1:0]     mul_a;
    logic [cpp_pkg::GAIN_W-1:0] mul_b;
    logic signed [cpp_pkg::MUL_P_W-1:0] mul_p;
    logic signed [AW-1:0]     acc_sh;
    logic signed [AW-1:0]     acc_rnd;
    logic                     out_free;

    cpp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_gains     (gains)
    );

    cpp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_drive_voltage = r_vout;
    assign out_free        = !r_out_valid || i_ready;

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_M0: begin
                mul_a = MW'(r_e);
                mul_b = gains.outer_kp;
            end
            S_M1: begin
                mul_a = MW'(r_ai);
                mul_b = gains.outer_ki;
            end
            S_M2: begin
                mul_a = MW'(r_d);
                mul_b = gains.outer_kd;
            end
            S_M4: begin
                mul_a = r_v;
                mul_b = gains.inner_kp;
            end
            S_M5: begin
                mul_a = MW'(r_si);
                mul_b = gains.inner_ki;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_AINT;
            S_AINT: n_state = S_M0;
            S_M0:   n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_TGT;
            S_TGT:  n_state = S_V;
            S_V:    n_state = S_TRI;
            S_TRI:  n_state = S_SINT;
            S_SINT: n_state = S_M4;
            S_M4:   n_state = S_M5;
            S_M5:   n_state = S_M6;
            S_M6:   n_state = S_CLMP;
            S_CLMP: n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // floor to Q.F and rounding toward zero for the voltage
    assign acc_sh  = r_acc >>> 8;
    assign acc_rnd = r_acc + (r_acc < 0 ? RND_ADD : '0);

    // controller state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_ai        <= '0;
            r_si        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            if (r_state == S_AINT) begin
                r_ai   <= INT_W'(sat(AW'(r_ai) + AW'(r_e), ANG_LIM));
                r_prev <= r_e;
            end
            if (r_state == S_SINT) r_si <= INT_W'(sat(AW'(r_si) + AW'(r_v), SPD_LIM));
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_e    <= i_angle_error;
                r_meas <= i_measured_speed;
            end
            S_AINT: r_d   <= (DW+1)'(r_e) - (DW+1)'(r_prev);
            S_M1:   r_acc <= AW'(mul_p);
            S_M2:   r_acc <= r_acc + AW'(mul_p);
            S_M3:   r_acc <= r_acc + AW'(mul_p);
            S_TGT:  r_tgt <= TW'(sat(acc_sh, VMAX));
            S_V:    r_v   <= MW'(AW'(r_tgt) - AW'(r_meas));
            S_TRI:  if (r_v > 0) r_v <= r_v + (r_v <<< 1);
            S_M5:   r_acc <= AW'(mul_p);
            S_M6:   r_acc <= r_acc + AW'(mul_p);
            S_CLMP: r_acc <= sat(r_acc, OUT_LIM);
            S_OUT:  if (out_free) r_vout <= OW'(acc_rnd >>> OUT_SHIFT);
            default: ;
        endcase
    end

    // no second item is taken right behind an accepted one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while an item is in flight");

    // voltage stays inside the saturation range
    a_volt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_drive_voltage <= V_LIM && o_drive_voltage >= -V_LIM))
        else $error("drive voltage outside limit");

    // integrators stay clamped
    a_ang_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW'(r_ai) <= ANG_LIM && AW'(r_ai) >= -ANG_LIM))
        else $error("angle integral outside limit");

    a_spd_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW'(r_si) <= SPD_LIM && AW'(r_si) >= -SPD_LIM))
        else $error("speed integral outside limit");

endmodule
